FILE: src/imh_pkg.sv
// Package for the indexed min-heap block: payload word types, status codes
// and controller states. No dependencies.
package imh_pkg;

  localparam int VID_W = 10;
  localparam int KEY_W = 32;
  localparam int CNT_W = 11;
  localparam int ST_W  = 3;

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DECREASED = 3'd1;
  localparam logic [ST_W-1:0] ST_IGNORED   = 3'd2;
  localparam logic [ST_W-1:0] ST_POPPED    = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [VID_W-1:0] vertex_id;
    logic [KEY_W-1:0] key_value;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VID_W-1:0] out_vertex;
    logic [KEY_W-1:0] out_key;
    logic [CNT_W-1:0] heap_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,   // sweep position table to absent
    S_IDLE,
    S_LOOKUP,  // position table read returns
    S_CHECK,   // slot read for decrease returns
    S_UP_RD,   // issue parent read
    S_UP_CMP,  // compare with parent, swap
    S_POP_RD,  // last slot read returns
    S_DN_RD,   // issue child reads
    S_DN_CMP,  // compare children and parent, swap
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic lookup;
    logic check;
    logic up_rd;
    logic up_cmp;
    logic pop_rd;
    logic dn_rd;
    logic dn_cmp;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic go_check;   // lookup found vertex present and valid: compare key
    logic go_up;      // start rise
    logic go_pop;     // pop on non-empty heap needing the last slot
    logic up_more;    // rise continues
    logic dn_more;    // sink continues
    logic dn_start;   // sink has children to look at
  } sts_t;

endpackage

FILE: src/imh_ctrl.sv
// Controller state machine of the indexed min-heap.
// Depends on imh_pkg.
module imh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_take,
  input  logic             out_busy,
  input  imh_pkg::sts_t    sts,
  output imh_pkg::cmd_t    cmd,
  output logic             idle
);

  imh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= imh_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    case (state)
      imh_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = imh_pkg::S_IDLE;
      end
      imh_pkg::S_IDLE: begin
        idle = !out_busy;
        if (in_take) state_next = imh_pkg::S_LOOKUP;
      end
      imh_pkg::S_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (sts.go_check)    state_next = imh_pkg::S_CHECK;
        else if (sts.go_up)  state_next = imh_pkg::S_UP_RD;
        else if (sts.go_pop) state_next = imh_pkg::S_POP_RD;
        else                 state_next = imh_pkg::S_DONE;
      end
      imh_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        state_next = sts.go_up ? imh_pkg::S_UP_RD : imh_pkg::S_DONE;
      end
      imh_pkg::S_UP_RD: begin
        cmd.up_rd = 1'b1;
        state_next = sts.up_more ? imh_pkg::S_UP_CMP : imh_pkg::S_DONE;
      end
      imh_pkg::S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_next = sts.up_more ? imh_pkg::S_UP_RD : imh_pkg::S_DONE;
      end
      imh_pkg::S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = imh_pkg::S_DN_RD;
      end
      imh_pkg::S_DN_RD: begin
        cmd.dn_rd = 1'b1;
        state_next = sts.dn_start ? imh_pkg::S_DN_CMP : imh_pkg::S_DONE;
      end
      imh_pkg::S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_next = sts.dn_more ? imh_pkg::S_DN_RD : imh_pkg::S_DONE;
      end
      imh_pkg::S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = imh_pkg::S_IDLE;
        end
      end
      default: state_next = imh_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: src/imh_dp.sv
// Datapath of the indexed min-heap: slot memories, position table, walk
// registers and result register. Depends on imh_pkg.
module imh_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int KEY_BITS     = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_take,
  input  imh_pkg::in_word_t   in_word,
  input  imh_pkg::cmd_t       cmd,
  output imh_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_stall,
  output imh_pkg::out_word_t  out_word
);

  localparam int PW = $clog2(MAX_VERTICES + 1);   // position / count width
  localparam int AW = $clog2(MAX_VERTICES);       // vertex index width

  // slot memories addressed by position-1; position table addressed by vertex
  logic [KEY_BITS-1:0] kmem [MAX_VERTICES];
  logic [AW-1:0]       vmem [MAX_VERTICES];
  logic [PW-1:0]       pmem [MAX_VERTICES];

  logic [PW-1:0] count;
  logic [AW-1:0] clr_idx;

  // item registers
  logic                op;
  logic [AW-1:0]       vtx;
  logic                vtx_ok;
  logic [KEY_BITS-1:0] key;
  logic [imh_pkg::ST_W-1:0] status;
  logic [AW-1:0]       pop_vtx;
  logic [KEY_BITS-1:0] pop_key;

  // walker: moving entry (mk,mv) at position pos
  logic [PW-1:0]       pos;
  logic [KEY_BITS-1:0] mk;
  logic [AW-1:0]       mv;

  // read ports (registered data)
  logic [PW-1:0]       prd;       // position table read
  logic [KEY_BITS-1:0] ka_rd, kb_rd;
  logic [AW-1:0]       va_rd, vb_rd;
  logic [AW-1:0]       ra_addr, rb_addr;

  // write port for slots; write port for position table
  logic                sw_en;
  logic [AW-1:0]       sw_addr;
  logic [KEY_BITS-1:0] sw_key;
  logic [AW-1:0]       sw_vtx;
  logic                pw_en;
  logic [AW-1:0]       pw_addr;
  logic [PW-1:0]       pw_data;

  logic [PW-1:0] left, right, parent;
  logic          has_right;
  logic          pick_right;
  logic [KEY_BITS-1:0] ck;
  logic [AW-1:0]       cv;
  logic [PW-1:0]       cpos;
  logic [PW+1:0]       left_w;

  assign left_w    = {1'b0, pos, 1'b0};
  assign left      = left_w[PW-1:0];
  assign right     = left + PW'(1);
  assign parent    = pos >> 1;
  assign has_right = (left_w + (PW+2)'(1)) <= (PW+2)'(count);
  assign pick_right = has_right && (kb_rd < ka_rd);
  assign ck   = pick_right ? kb_rd : ka_rd;
  assign cv   = pick_right ? vb_rd : va_rd;
  assign cpos = pick_right ? right : left;

  // status toward controller
  always_comb begin
    sts = '0;
    sts.clr_done = (clr_idx == AW'(MAX_VERTICES - 1));
    sts.go_check = !op && vtx_ok && (prd != '0);
    sts.go_up    = cmd.check ? (key < ka_rd)
                 : (!op && vtx_ok && prd == '0 && count < PW'(MAX_VERTICES));
    sts.go_pop   = op && (count != '0);
    sts.up_more  = cmd.up_rd ? (pos > PW'(1)) : (mk < ka_rd);
    sts.dn_start = ({1'b0, left_w} <= (PW+3)'(count)) && (count != '0);
    sts.dn_more  = (ck < mk);
  end

  // read addresses
  always_comb begin
    ra_addr = AW'(pos - PW'(1));
    rb_addr = AW'(pos - PW'(1));
    if (cmd.up_rd) ra_addr = AW'(parent - PW'(1));
    else if (cmd.lookup) begin
      // last slot for pop, the vertex's own slot for decrease
      ra_addr = op ? AW'(count - PW'(1)) : AW'(prd - PW'(1));
    end
    else if (cmd.dn_rd) begin
      ra_addr = AW'(left - PW'(1));
      rb_addr = AW'(right - PW'(1));
    end
  end

  // writes
  always_comb begin
    sw_en = 1'b0; sw_addr = AW'(pos - PW'(1)); sw_key = mk; sw_vtx = mv;
    pw_en = 1'b0; pw_addr = mv; pw_data = pos;
    if (cmd.clr_step) begin
      pw_en = 1'b1; pw_addr = clr_idx; pw_data = '0;
    end else if (cmd.up_rd && !sts.up_more) begin
      sw_en = 1'b1; pw_en = 1'b1;              // settle moving entry
    end else if (cmd.up_cmp) begin
      if (mk < ka_rd) begin                    // parent moves down into pos
        sw_en = 1'b1; sw_key = ka_rd; sw_vtx = va_rd;
        pw_en = 1'b1; pw_addr = va_rd; pw_data = pos;
      end else begin
        sw_en = 1'b1; pw_en = 1'b1;
      end
    end else if (cmd.pop_rd) begin
      pw_en = 1'b1; pw_addr = vb_rd; pw_data = '0;   // root vertex goes absent
    end else if (cmd.dn_rd && !sts.dn_start) begin
      if (count != '0) begin sw_en = 1'b1; pw_en = 1'b1; end
    end else if (cmd.dn_cmp) begin
      if (ck < mk) begin                       // child moves up into pos
        sw_en = 1'b1; sw_key = ck; sw_vtx = cv;
        pw_en = 1'b1; pw_addr = cv; pw_data = pos;
      end else begin
        sw_en = 1'b1; pw_en = 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (sw_en) begin
      kmem[sw_addr] <= sw_key;
      vmem[sw_addr] <= sw_vtx;
    end
    ka_rd <= kmem[ra_addr];
    va_rd <= vmem[ra_addr];
    kb_rd <= kmem[rb_addr];
    vb_rd <= vmem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    prd <= pmem[AW'(in_word.vertex_id)];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + AW'(1);
      if (cmd.lookup && sts.go_up) count <= count + PW'(1);
      if (cmd.lookup && sts.go_pop) count <= count - PW'(1);
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op     <= in_word.opcode;
      vtx    <= AW'(in_word.vertex_id);
      vtx_ok <= (32'(in_word.vertex_id) < 32'(MAX_VERTICES));
      key    <= KEY_BITS'(in_word.key_value);
      pos    <= PW'(1);
      pop_vtx <= '0;
      pop_key <= '0;
      status <= in_word.opcode ? imh_pkg::ST_EMPTY : imh_pkg::ST_IGNORED;
    end
    if (cmd.lookup) begin
      mk <= key;
      mv <= vtx;
      if (sts.go_check) pos <= prd;
      else if (sts.go_up) begin
        pos <= count + PW'(1);
        status <= imh_pkg::ST_INSERTED;
      end else if (sts.go_pop) begin
        status <= imh_pkg::ST_POPPED;
        pos <= PW'(1);
      end
    end
    if (cmd.check && sts.go_up) status <= imh_pkg::ST_DECREASED;
    if (cmd.up_cmp && (mk < ka_rd)) pos <= parent;
    // at pop_rd: slot 1 data is in b port, last slot in a port
    if (cmd.pop_rd) begin
      pop_key <= kb_rd;
      pop_vtx <= vb_rd;
      mk <= ka_rd;
      mv <= va_rd;
    end
    if (cmd.dn_cmp && (ck < mk)) pos <= cpos;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word.status     <= status;
      out_word.out_vertex <= imh_pkg::VID_W'(pop_vtx);
      out_word.out_key    <= imh_pkg::KEY_W'(pop_key);
      out_word.heap_count <= imh_pkg::CNT_W'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(MAX_VERTICES)) else $error("count beyond capacity");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.up_cmp || cmd.dn_cmp) |-> (pos != '0)) else $error("walk at position zero");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_word)) else $error("result changed");
`endif

endmodule

FILE: src/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with decrease-key. A push word (opcode 0) inserts
// an absent vertex or lowers the key of a present one, then sifts it up; a
// pop word (opcode 1) removes the root, reports its vertex and key, and sifts
// the last entry down from the root (ties go to the left child). One item at
// a time: each heap level walked costs a registered memory read and a
// compare-and-write; a decrease-key adds a key compare and a pop adds a read
// of the last slot. After reset a clearing pass marks every vertex absent
// before the first word is taken. A finished result sits in an output
// register; the block takes the next word once it is delivered, so output
// stall holds off the next word. Any other push reports ignored.
module indexed_min_heap_decrease_key #(
  parameter int MAX_VERTICES = 1024,
  parameter int KEY_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  imh_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output imh_pkg::out_word_t out_word
);

  imh_pkg::cmd_t cmd;
  imh_pkg::sts_t sts;
  logic idle;
  logic in_take;

  // take a word only when idle and the result register is free
  assign in_stall = !idle;
  assign in_take  = in_valid && idle;

  // read slot 1 on port b while lookup reads the last slot on port a
  imh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_take(in_take), .out_busy(out_valid),
    .sts(sts), .cmd(cmd), .idle(idle)
  );

  imh_dp #(.MAX_VERTICES(MAX_VERTICES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_take(in_take), .in_word(in_word),
    .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_take) else $error("word taken while result pending");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall) else $error("second word taken back to back");
  a_word_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result word repeated");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the indexed min-heap with decrease-key.
// Depends on imh_pkg and indexed_min_heap_decrease_key; predicts every result word.
`timescale 1ns / 100ps
module testbench;

  localparam int NV = 1024;
  localparam int RAND_ITEMS = 400;
  localparam int FILL_POPS = 150;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  imh_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  imh_pkg::out_word_t out_word;

  indexed_min_heap_decrease_key dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: heap slots are 1-based, position 0 means absent.
  logic [imh_pkg::KEY_W-1:0] heap_key [1:NV];
  logic [imh_pkg::VID_W-1:0] heap_vtx [1:NV];
  int unsigned      vtx_slot [0:NV-1];
  int unsigned      heap_size;

  imh_pkg::out_word_t pending_results [$];
  int errors = 0;
  int cycles = 0;

  // Directed table; hand-typed expectations where they are obvious.
  typedef struct {
    imh_pkg::in_word_t  w;
    bit                 typed;
    imh_pkg::out_word_t exp;
  } vec_t;
  vec_t vecs [$];

  function automatic void place(int unsigned p, logic [imh_pkg::KEY_W-1:0] k,
                                logic [imh_pkg::VID_W-1:0] v);
    heap_key[p] = k;
    heap_vtx[p] = v;
    vtx_slot[v] = p;
  endfunction

  function automatic void trade(int unsigned a, int unsigned b);
    logic [imh_pkg::KEY_W-1:0] k;
    logic [imh_pkg::VID_W-1:0] v;
    k = heap_key[a];
    v = heap_vtx[a];
    place(a, heap_key[b], heap_vtx[b]);
    place(b, k, v);
  endfunction

  function automatic void float_up(int unsigned p);
    while (p > 1 && heap_key[p] < heap_key[p>>1]) begin
      trade(p, p >> 1);
      p = p >> 1;
    end
  endfunction

  function automatic void settle_down(int unsigned p);
    int unsigned c;
    forever begin
      c = 2 * p;
      if (c > heap_size) break;
      if (c + 1 <= heap_size && heap_key[c+1] < heap_key[c]) c = c + 1;
      if (heap_key[c] < heap_key[p]) begin
        trade(p, c);
        p = c;
      end else break;
    end
  endfunction

  // Apply one word to the predicted heap and return the expected result.
  function automatic imh_pkg::out_word_t heap_apply(imh_pkg::in_word_t w);
    imh_pkg::out_word_t r;
    int unsigned p;
    r = '0;
    if (w.opcode == imh_pkg::OP_PUSH) begin
      p = vtx_slot[w.vertex_id];
      if (p == 0) begin
        if (heap_size >= NV) r.status = imh_pkg::ST_IGNORED;
        else begin
          heap_size++;
          place(heap_size, w.key_value, w.vertex_id);
          float_up(heap_size);
          r.status = imh_pkg::ST_INSERTED;
        end
      end else if (w.key_value < heap_key[p]) begin
        heap_key[p] = w.key_value;
        float_up(p);
        r.status = imh_pkg::ST_DECREASED;
      end else r.status = imh_pkg::ST_IGNORED;
    end else if (heap_size == 0) r.status = imh_pkg::ST_EMPTY;
    else begin
      r.out_vertex = heap_vtx[1];
      r.out_key = heap_key[1];
      vtx_slot[heap_vtx[1]] = 0;
      if (heap_size > 1) place(1, heap_key[heap_size], heap_vtx[heap_size]);
      heap_size--;
      if (heap_size > 0) settle_down(1);
      r.status = imh_pkg::ST_POPPED;
    end
    r.heap_count = heap_size[imh_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic imh_pkg::in_word_t mk(logic op, int unsigned v,
                                           logic [imh_pkg::KEY_W-1:0] k);
    imh_pkg::in_word_t w;
    w.opcode = op;
    w.vertex_id = v[imh_pkg::VID_W-1:0];
    w.key_value = k;
    return w;
  endfunction

  function automatic imh_pkg::out_word_t res(logic [imh_pkg::ST_W-1:0] s, int unsigned v,
                                             logic [imh_pkg::KEY_W-1:0] k, int unsigned n);
    imh_pkg::out_word_t r;
    r.status = s;
    r.out_vertex = v[imh_pkg::VID_W-1:0];
    r.out_key = k;
    r.heap_count = n[imh_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic add_row(imh_pkg::in_word_t w, bit typed, imh_pkg::out_word_t e);
    vec_t t;
    t.w = w;
    t.typed = typed;
    t.exp = e;
    vecs.push_back(t);
  endtask

  // Sender: hold the word until accepted; expectations are queued on acceptance.
  task automatic send_word(imh_pkg::in_word_t w, bit typed, imh_pkg::out_word_t e);
    imh_pkg::out_word_t p;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    p = heap_apply(w);
    if (typed && p !== e)
      $display("%0t directed row disagrees with predictor: table %h predictor %h",
               $time, e, p);
    pending_results.push_back(typed ? e : p);
  endtask

  int burst_left = 0;

  // Break the stream into bursts with random gaps; the valid stays high inside a burst.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random word, biased toward a live heap: small vertex pool most of the time.
  function automatic imh_pkg::in_word_t rand_word(int unsigned pool, int unsigned pop_pct);
    imh_pkg::in_word_t w;
    logic [imh_pkg::KEY_W-1:0] k;
    int unsigned v;
    v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NV - 1) : $urandom_range(0, pool);
    case ($urandom_range(0, 3))
      0: k = $urandom();
      1: k = $urandom_range(0, 63);
      2: k = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: k = $urandom_range(0, 4095);
    endcase
    w = mk(($urandom_range(0, 99) < pop_pct) ? imh_pkg::OP_POP : imh_pkg::OP_PUSH, v, k);
    if (w.opcode == imh_pkg::OP_POP && $urandom_range(0, 1)) begin
      w.vertex_id = imh_pkg::VID_W'($urandom());
      w.key_value = $urandom();
    end
    return w;
  endfunction

  // Receiver: stall on its own pattern, with quiet stretches of no stalling.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Check each delivered word against the oldest expectation.
  always @(posedge clk) begin
    imh_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_word);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_word.status !== e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, out_word.status);
          errors++;
        end
        if (out_word.out_vertex !== e.out_vertex) begin
          $display("%0t out_vertex: expected %0d actual %0d", $time, e.out_vertex,
                   out_word.out_vertex);
          errors++;
        end
        if (out_word.out_key !== e.out_key) begin
          $display("%0t out_key: expected %h actual %h", $time, e.out_key, out_word.out_key);
          errors++;
        end
        if (out_word.heap_count !== e.heap_count) begin
          $display("%0t heap_count: expected %0d actual %0d", $time, e.heap_count,
                   out_word.heap_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: the clearing pass plus many times the slowest run fits well inside.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    for (int i = 0; i < NV; i++) vtx_slot[i] = 0;
    heap_size = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: empty pop, extremes, decrease, ignore, ties, reinsertion.
    add_row(mk(imh_pkg::OP_POP, 0, 0), 1, res(imh_pkg::ST_EMPTY, 0, 0, 0));
    add_row(mk(imh_pkg::OP_POP, 1023, 32'hFFFF_FFFF), 1, res(imh_pkg::ST_EMPTY, 0, 0, 0));
    add_row(mk(imh_pkg::OP_PUSH, 1023, 32'hFFFF_FFFF), 1,
            res(imh_pkg::ST_INSERTED, 0, 0, 1));
    add_row(mk(imh_pkg::OP_PUSH, 1023, 32'hFFFF_FFFF), 1,
            res(imh_pkg::ST_IGNORED, 0, 0, 1));
    add_row(mk(imh_pkg::OP_PUSH, 0, 0), 1, res(imh_pkg::ST_INSERTED, 0, 0, 2));
    add_row(mk(imh_pkg::OP_PUSH, 0, 5), 1, res(imh_pkg::ST_IGNORED, 0, 0, 2));
    add_row(mk(imh_pkg::OP_PUSH, 1023, 32'h7FFF_FFFF), 1,
            res(imh_pkg::ST_DECREASED, 0, 0, 2));
    add_row(mk(imh_pkg::OP_PUSH, 341, 32'h5555_5555), 0, '0);
    add_row(mk(imh_pkg::OP_PUSH, 682, 32'hAAAA_AAAA), 0, '0);
    add_row(mk(imh_pkg::OP_PUSH, 5, 100), 0, '0);
    add_row(mk(imh_pkg::OP_PUSH, 6, 100), 0, '0);
    add_row(mk(imh_pkg::OP_PUSH, 7, 100), 0, '0);
    add_row(mk(imh_pkg::OP_PUSH, 682, 0), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 1, res(imh_pkg::ST_POPPED, 0, 0, 6));
    add_row(mk(imh_pkg::OP_POP, 0, 0), 1, res(imh_pkg::ST_POPPED, 682, 0, 5));
    add_row(mk(imh_pkg::OP_POP, 0, 0), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 0, '0);
    add_row(mk(imh_pkg::OP_PUSH, 0, 1), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 0, '0);
    add_row(mk(imh_pkg::OP_POP, 0, 0), 1, res(imh_pkg::ST_EMPTY, 0, 0, 0));
    foreach (vecs[i]) begin
      send_word(vecs[i].w, vecs[i].typed, vecs[i].exp);
      pace();
    end
    // Hold off until the directed part has fully drained.
    drain();

    // Random phases: small pools for decrease-key and ties, then a deep fill.
    n = 0;
    while (n < RAND_ITEMS) begin
      int unsigned pool, pop_pct;
      case ((n / 100) % 4)
        0: begin pool = 15;  pop_pct = 35; end
        1: begin pool = 127; pop_pct = 25; end
        2: begin pool = 1023; pop_pct = 10; end
        default: begin pool = 63; pop_pct = 55; end
      endcase
      send_word(rand_word(pool, pop_pct), 0, '0);
      pace();
      n++;
      if (n == RAND_ITEMS / 2) drain();
    end

    // Push every vertex to reach a full heap, then pop part of it again.
    for (int v = 0; v < NV; v++) begin
      send_word(mk(imh_pkg::OP_PUSH, v, $urandom()), 0, '0);
      pace();
    end
    send_word(mk(imh_pkg::OP_PUSH, $urandom_range(0, NV - 1), 32'hFFFF_FFFF), 0, '0);
    for (int i = 0; i < FILL_POPS; i++) begin
      send_word(mk(imh_pkg::OP_POP, $urandom(), $urandom()), 0, '0);
      pace();
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
